// ----- src/wsd_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
`default_nettype none
package wsd_pkg;

  localparam int unsigned LEN_W = 64;
  localparam int unsigned KEY_W = 32;

  // Seven-bit length codes that select an extended length field
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  // Byte index of the last byte in each multi-byte header field
  localparam logic [2:0] EXT16_LAST_IDX = 3'd1;
  localparam logic [2:0] EXT64_LAST_IDX = 3'd7;
  localparam logic [2:0] KEY_LAST_IDX   = 3'd3;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_KEY   = 3'd4,
    PH_PAY   = 3'd5,
    PH_SKIP  = 3'd6
  } wsd_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } wsd_in_t;

  typedef struct packed {
    logic             result_kind;
    logic             fin_bit;
    logic [2:0]       rsv_bits;
    logic [3:0]       frame_opcode;
    logic             masked;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       data_out;
    logic             frame_end;
  } wsd_out_t;

  // Parser to result register handoff
  typedef struct packed {
    logic take;   // beat in the input register is consumed this cycle
    logic emit;   // that beat produces a result
  } wsd_ctl_t;

endpackage
`default_nettype wire

// ----- src/wsd_in_reg.sv -----
// Input register: holds one accepted beat until the parser consumes it.
`default_nettype none
module wsd_in_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire wsd_pkg::wsd_in_t in_data,
  input  wire logic            take,
  output logic                 beat_valid,
  output wsd_pkg::wsd_in_t     beat
);
  import wsd_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  wsd_in_t data_r;

  assign in_ready   = !valid_r || take;
  assign beat_valid = valid_r;
  assign beat       = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule
`default_nettype wire

// ----- src/wsd_parser.sv -----
// Frame parser: header decode, extended length, mask key and payload unmasking.
`default_nettype none
module wsd_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             beat_valid,
  input  wire wsd_pkg::wsd_in_t beat,
  input  wire logic             res_can_load,
  output wsd_pkg::wsd_ctl_t     ctl,
  output wsd_pkg::wsd_out_t     res
);
  import wsd_pkg::*;

  wsd_phase_t       phase_r, phase_nxt, ph;
  logic [7:0]       hdr_r, hdr_nxt;
  logic             mask_r, mask_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;   // payload bytes still to come
  logic [2:0]       cnt_r, cnt_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [1:0]       idx_r, idx_nxt;   // key byte index, payload count mod 4
  logic             len_zero_r, len_zero_nxt;

  logic             emit;
  logic             take;
  logic             finish;
  logic             fin_zero;
  logic [7:0]       key_byte;
  logic             rem_last;
  logic [2:0]       ext_last;

  assign ph       = beat.frame_start ? PH_HDR0 : phase_r;
  assign rem_last = (rem_r == {{(LEN_W-1){1'b0}}, 1'b1});
  assign ext_last = (ph == PH_EXT16) ? EXT16_LAST_IDX : EXT64_LAST_IDX;

  always_comb begin
    unique case (idx_r)
      2'd0: key_byte = key_r[31:24];
      2'd1: key_byte = key_r[23:16];
      2'd2: key_byte = key_r[15:8];
      2'd3: key_byte = key_r[7:0];
      default: key_byte = key_r[31:24];
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    hdr_nxt      = hdr_r;
    mask_nxt     = mask_r;
    len_nxt      = len_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    key_nxt      = key_r;
    idx_nxt      = idx_r;
    len_zero_nxt = len_zero_r;
    finish       = 1'b0;
    emit         = 1'b0;

    res.result_kind    = KIND_HEADER;
    res.fin_bit        = hdr_r[7];
    res.rsv_bits       = hdr_r[6:4];
    res.frame_opcode   = hdr_r[3:0];
    res.masked         = mask_r;
    res.payload_length = len_r;
    res.data_out       = 8'd0;
    res.frame_end      = 1'b0;

    unique case (ph)
      PH_HDR1: begin
        mask_nxt = beat.data_byte[7];
        cnt_nxt  = 3'd0;
        len_nxt  = '0;
        if (beat.data_byte[6:0] == LEN_CODE_EXT16) begin
          phase_nxt = PH_EXT16;
        end else if (beat.data_byte[6:0] == LEN_CODE_EXT64) begin
          phase_nxt = PH_EXT64;
        end else begin
          len_nxt = {{(LEN_W-7){1'b0}}, beat.data_byte[6:0]};
          finish  = 1'b1;
        end
      end
      PH_EXT16, PH_EXT64: begin
        len_nxt = {len_r[LEN_W-9:0], beat.data_byte};
        if (cnt_r == ext_last) begin
          finish = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[KEY_W-9:0], beat.data_byte};
        if (cnt_r == KEY_LAST_IDX) begin
          cnt_nxt   = 3'd0;
          phase_nxt = len_zero_r ? PH_HDR0 : PH_PAY;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      PH_PAY: begin
        rem_nxt = rem_r - {{(LEN_W-1){1'b0}}, 1'b1};
        idx_nxt = idx_r + 2'd1;
        if (rem_last) begin
          phase_nxt = PH_HDR0;
        end
        emit            = 1'b1;
        res.result_kind = KIND_PAYLOAD;
        res.data_out    = beat.data_byte ^ key_byte;
        res.frame_end   = rem_last;
      end
      PH_SKIP: begin
        rem_nxt = rem_r - {{(LEN_W-1){1'b0}}, 1'b1};
        if (rem_last) begin
          phase_nxt = PH_HDR0;
        end
      end
      default: begin
        // first header byte; also covers the unused phase code
        hdr_nxt   = beat.data_byte;
        phase_nxt = PH_HDR1;
      end
    endcase

    fin_zero = (len_nxt == '0);
    if (finish) begin
      rem_nxt      = len_nxt;
      len_zero_nxt = fin_zero;
      cnt_nxt      = 3'd0;
      idx_nxt      = 2'd0;
      if (mask_nxt) begin
        phase_nxt = PH_KEY;
      end else begin
        phase_nxt = fin_zero ? PH_HDR0 : PH_SKIP;
      end
      emit               = 1'b1;
      res.result_kind    = KIND_HEADER;
      res.masked         = mask_nxt;
      res.payload_length = len_nxt;
      res.data_out       = 8'd0;
      res.frame_end      = !mask_nxt || fin_zero;
    end
  end

  // A beat that yields nothing never waits on the result register
  assign take     = beat_valid && (res_can_load || !emit);
  assign ctl.take = take;
  assign ctl.emit = take && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR0;
      hdr_r      <= 8'd0;
      mask_r     <= 1'b0;
      len_r      <= '0;
      rem_r      <= '0;
      cnt_r      <= 3'd0;
      key_r      <= '0;
      idx_r      <= 2'd0;
      len_zero_r <= 1'b1;
    end else if (take) begin
      phase_r    <= phase_nxt;
      hdr_r      <= hdr_nxt;
      mask_r     <= mask_nxt;
      len_r      <= len_nxt;
      rem_r      <= rem_nxt;
      cnt_r      <= cnt_nxt;
      key_r      <= key_nxt;
      idx_r      <= idx_nxt;
      len_zero_r <= len_zero_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/wsd_out_reg.sv -----
// Result register: holds one result beat until the receiver takes it.
`default_nettype none
module wsd_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire wsd_pkg::wsd_ctl_t ctl,
  input  wire wsd_pkg::wsd_out_t res,
  output logic                   can_load,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output wsd_pkg::wsd_out_t      out_data
);
  import wsd_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  wsd_out_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.emit) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      data_r <= res;
    end
  end

endmodule
`default_nettype wire

// ----- src/websocket_frame_deframer_core.sv -----
// WebSocket frame deframer: byte stream in, header and unmasked payload results out.
//
// in_valid/in_ready/in_data carry one frame byte per beat; frame_start marks the
// first byte of a frame and restarts the parser wherever it stands. Without it,
// the parser picks up the next header by itself once a frame completes.
// out_valid/out_ready/out_data carry results: one header beat per frame once its
// length is known, then one beat per masked payload byte, XORed with the key.
// Unmasked payload bytes are consumed with no result. frame_end flags the last
// result of a frame.
// Each accepted byte sits in the input register while the parse logic loads its
// result, if it gives one, into the result register, which drives out_data.
// Throughput: one byte per cycle, while no result waits on a stalled receiver;
// the parse step between the two registers is combinational.
// A stalled receiver holds the result register; the input register still takes
// one more beat, and bytes that give no result keep flowing past a full result
// register. Reset (rst_n low, synchronous) empties both registers and returns
// the parser to waiting for a first header byte.
`default_nettype none
module websocket_frame_deframer_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire wsd_pkg::wsd_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output wsd_pkg::wsd_out_t     out_data
);
  import wsd_pkg::*;

  logic     beat_valid;
  wsd_in_t  beat;
  wsd_ctl_t ctl;
  wsd_out_t res;
  logic     res_can_load;

  wsd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (ctl.take),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  wsd_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .beat_valid   (beat_valid),
    .beat         (beat),
    .res_can_load (res_can_load),
    .ctl          (ctl),
    .res          (res)
  );

  wsd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .res       (res),
    .can_load  (res_can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
